### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes for the min-priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

  localparam int unsigned CapLog2    = 10;
  localparam int unsigned QueueDepth = (1 << CapLog2) - 1;

  typedef logic signed [31:0]      key_t;
  typedef logic [CapLog2-1:0]      count_t;
  typedef logic [1:0]              action_t;
  typedef logic [1:0]              status_t;

  // request action codes
  localparam action_t ActInsert = 2'd0;
  localparam action_t ActRemove = 2'd1;
  localparam action_t ActPeek   = 2'd2;

  // response status codes
  localparam status_t StOk    = 2'd0;
  localparam status_t StEmpty = 2'd1;
  localparam status_t StFull  = 2'd2;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic remove;
    key_t key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### design/mpq_req_if.sv
// ----------------------------------------------------------------------------
// mpq_req_if
// Request channel: action and key with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpq_req_if;
  import mpq_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  key_t    key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

`default_nettype wire

### design/mpq_rsp_if.sv
// ----------------------------------------------------------------------------
// mpq_rsp_if
// Response channel: status and key with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpq_rsp_if;
  import mpq_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  key_t    min_key;

  modport source (output valid, output status, output min_key, input ready);
  modport sink   (input valid, input status, input min_key, output ready);
endinterface

`default_nettype wire

### design/min_priority_queue.sv
// Result: registered, and valid in the cycle after its request is accepted.
// Throughput: one request per cycle while the response side takes results;
//   the single response register sets this figure.
// Insert and remove reach every cell of the chain at the edge that accepts them.
// Reset: clears the entry count and the response valid; cell keys are left
//   as they are, since only occupied cells are ever read. No clearing pass.
// ----------------------------------------------------------------------------
// min_priority_queue
// Min-priority queue of signed 32-bit keys built as a sorted systolic chain.
// ----------------------------------------------------------------------------
`default_nettype none

module min_priority_queue import mpq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mpq_req_if.sink   req_i,
  mpq_rsp_if.source rsp_o
);

  // Occupancy and handshake
  count_t  count_q, count_d;
  logic    rsp_valid_q;
  status_t status_q, status_d;
  key_t    min_key_q, min_key_d;

  logic       req_fire;
  logic       is_empty;
  logic       is_full;
  cell_ctrl_t ctrl;
  key_t       head_key;

  // a new request may enter whenever the response register is free or
  // being drained in this cycle
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == count_t'(QueueDepth));

  // Command broadcast to the chain: dropped when the request cannot act
  always_comb begin
    ctrl.key    = req_i.key;
    ctrl.insert = req_fire && (req_i.action == ActInsert) && !is_full;
    ctrl.remove = req_fire && (req_i.action == ActRemove) && !is_empty;
  end

  mpq_chain u_chain (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .count_i    (count_q),
    .head_key_o (head_key)
  );

  // Result of the request, from the state seen before it
  always_comb begin
    status_d  = StOk;
    min_key_d = '0;
    case (req_i.action)
      ActInsert: begin
        if (is_full) status_d = StFull;
      end
      ActRemove, ActPeek: begin
        if (is_empty) begin
          status_d = StEmpty;
        end else begin
          min_key_d = head_key;
        end
      end
      default: begin
        // unused code: no effect, ok with zero key
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.insert) begin
      count_d = count_q + count_t'(1);
    end else if (ctrl.remove) begin
      count_d = count_q - count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (req_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Response payload; loaded only on acceptance, so it holds under stall
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      status_q  <= status_d;
      min_key_q <= min_key_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.status  = status_q;
  assign rsp_o.min_key = min_key_q;

endmodule

`default_nettype wire

### design/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain: holds a key, shifts right on insert, left on
// remove.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_cell import mpq_pkg::*; (
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic       occ_i,
  input  wire key_t       left_key_i,
  input  wire logic       left_gt_i,
  input  wire key_t       right_key_i,
  output      key_t       key_o,
  output      logic       gt_o
);

  key_t key_q, key_d;

  // empty slots act as +infinity, so gt is monotonic along the chain
  assign gt_o  = !occ_i || (ctrl_i.key < key_q);
  assign key_o = key_q;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.insert) begin
      if (gt_o) begin
        key_d = left_gt_i ? left_key_i : ctrl_i.key;
      end
    end else if (ctrl_i.remove) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

`default_nettype wire

### design/mpq_chain.sv
// ----------------------------------------------------------------------------
// mpq_chain
// Row of sorted cells; cell 0 always holds the minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_chain import mpq_pkg::*; (
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire count_t     count_i,
  output      key_t       head_key_o
);

  key_t key_w [QueueDepth];
  logic gt_w  [QueueDepth];

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic occ;
    key_t left_key;
    logic left_gt;
    key_t right_key;

    assign occ = count_t'(i) < count_i;

    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_key = key_w[i-1];
      assign left_gt  = gt_w[i-1];
    end

    if (i == QueueDepth - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_notlast
      assign right_key = key_w[i+1];
    end

    mpq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl_i),
      .occ_i       (occ),
      .left_key_i  (left_key),
      .left_gt_i   (left_gt),
      .right_key_i (right_key),
      .key_o       (key_w[i]),
      .gt_o        (gt_w[i])
    );
  end

  assign head_key_o = key_w[0];

endmodule

`default_nettype wire

### design/mpq_checker.sv
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks of the min-priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mpq_checker import mpq_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    req_valid_i,
  input wire logic    req_ready_i,
  input wire logic    rsp_valid_i,
  input wire logic    rsp_ready_i,
  input wire status_t rsp_status_i,
  input wire key_t    rsp_min_key_i
);

  `MPQ_ASSERT_NXT(a_req_gives_rsp, clk_i, rst_ni, req_valid_i && req_ready_i,
                  rsp_valid_i, "accepted request produced no response")

  `MPQ_ASSERT_IMP(a_stall_only_when_full, clk_i, rst_ni, !req_ready_i,
                  rsp_valid_i && !rsp_ready_i, "request side stalled needlessly")

  `MPQ_ASSERT_IMP(a_zero_key_on_error, clk_i, rst_ni,
                  rsp_valid_i && (rsp_status_i != StOk),
                  rsp_min_key_i == '0, "nonzero key with error status")

  `MPQ_ASSERT_NXT(a_rsp_holds, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i,
                  rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_min_key_i),
                  "stalled response changed")

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_min_key_i (rsp_o.min_key)
);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for min_priority_queue. A driver and a monitor run as
// clocked blocks. The driver takes requests from a queue that the stimulus
// process fills. The monitor keeps its own multiset of held keys, predicts
// each response and checks every response against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;
  import mpq_pkg::*;

  // unused action code: the block must answer ok/zero and leave state alone
  localparam action_t     ActUnused  = 2'd3;
  // cycles with no request and no response taken before the run is abandoned
  localparam int unsigned StallLimit = 4000;
  // one long receiver hold-off, so the response register fills and the
  // request side backs up behind it
  localparam int unsigned LongHold   = 120;
  localparam int unsigned HoldAfter  = 100;

  typedef struct packed {
    action_t action;
    key_t    key;
  } req_item_t;

  typedef struct packed {
    status_t status;
    key_t    min_key;
  } rsp_item_t;

  logic clk_i;
  logic rst_ni;

  mpq_req_if req_if ();
  mpq_rsp_if rsp_if ();

  min_priority_queue u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // request items waiting for the driver
  req_item_t   req_pending[$];
  // predicted responses, oldest first
  rsp_item_t   rsp_predicted[$];
  // keys the queue should be holding right now (order irrelevant)
  key_t        held_keys[$];

  int unsigned req_total;     // requests handed to the driver so far
  int unsigned rsp_count;     // responses taken from the block so far
  int unsigned err_count;
  int unsigned quiet_cycles;
  int unsigned src_gap;
  int unsigned sink_gap;
  int unsigned fill_len;
  int unsigned drain_len;
  bit          req_taken;     // request handshake seen at the last rising edge
  bit          no_idle;       // suppresses random gaps on both sides
  bit          long_hold_done;
  req_item_t   mon_req;
  rsp_item_t   mon_want;

  // --------------------------------------------------------------------------
  // clock: 10 ns period
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor: applies one request to held_keys and returns the response
  // --------------------------------------------------------------------------
  function automatic rsp_item_t apply_queue_op(req_item_t item);
    rsp_item_t   r;
    int unsigned best;
    r.status  = StOk;
    r.min_key = '0;
    best      = 0;
    case (item.action)
      ActInsert: begin
        // full queue drops the key
        if (held_keys.size() >= QueueDepth) r.status = StFull;
        else held_keys.push_back(item.key);
      end
      ActRemove, ActPeek: begin
        if (held_keys.size() == 0) begin
          r.status = StEmpty;
        end else begin
          for (int i = 1; i < held_keys.size(); i++)
            if (held_keys[i] < held_keys[best]) best = i;
          r.min_key = held_keys[best];
          // with equal keys any copy may go; the value is the same
          if (item.action == ActRemove) held_keys.delete(best);
        end
      end
      default: ;  // unused code: no change
    endcase
    return r;
  endfunction

  // mostly back-to-back, sometimes short gaps, rarely long ones
  function automatic int unsigned pick_gap();
    int unsigned p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // full-range keys, plus clustered small values for duplicates and extremes
  function automatic key_t pick_key();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return key_t'($urandom);
    if (p < 85) return key_t'(int'($urandom_range(0, 15)) - 8);
    if (p < 92) return key_t'(32'h7fff_ffff);
    return key_t'(32'h8000_0000);
  endfunction

  function automatic action_t pick_action(int unsigned w_ins, int unsigned w_rem,
                                          int unsigned w_peek);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < w_ins) return ActInsert;
    if (p < w_ins + w_rem) return ActRemove;
    if (p < w_ins + w_rem + w_peek) return ActPeek;
    return ActUnused;
  endfunction

  task automatic send_req(action_t action, key_t key);
    req_item_t item;
    item.action = action;
    item.key    = key;
    req_pending.push_back(item);
    req_total++;
  endtask

  // block the stimulus until every request has been answered
  task automatic wait_idle();
    wait (rsp_count >= req_total);
  endtask

  // --------------------------------------------------------------------------
  // request driver: changes inputs on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      // load a new request once the current one was taken or none is up
      if (!req_if.valid || req_taken) begin
        if (src_gap > 0) begin
          req_if.valid <= 1'b0;
          src_gap      <= src_gap - 1;
        end else if (req_pending.size() > 0) begin
          req_if.valid  <= 1'b1;
          req_if.action <= req_pending[0].action;
          req_if.key    <= req_pending[0].key;
          void'(req_pending.pop_front());
          src_gap       <= pick_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // response receiver: random back-pressure, plus one long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && rsp_count >= HoldAfter) begin
        long_hold_done <= 1'b1;
        sink_gap       <= LongHold;
        rsp_if.ready   <= 1'b0;
      end else if (sink_gap > 0) begin
        rsp_if.ready <= 1'b0;
        sink_gap     <= sink_gap - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) sink_gap <= pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: samples both handshakes on the rising edge, checks, predicts
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    req_taken = rst_ni && req_if.valid && req_if.ready;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_count++;
        if (rsp_predicted.size() == 0) begin
          err_count++;
          $display("%0t: response with none outstanding, status %0d min_key %0d",
                   $realtime, rsp_if.status, rsp_if.min_key);
        end else begin
          mon_want = rsp_predicted.pop_front();
          if (rsp_if.status !== mon_want.status) begin
            err_count++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $realtime, mon_want.status, rsp_if.status);
          end
          if (rsp_if.min_key !== mon_want.min_key) begin
            err_count++;
            $display("%0t: min_key mismatch, expected %0d, actual %0d",
                     $realtime, mon_want.min_key, rsp_if.min_key);
          end
        end
      end
      // a request taken now is answered only from the response register,
      // so predicting after the check keeps the order right
      if (req_taken) begin
        mon_req.action = req_if.action;
        mon_req.key    = req_if.key;
        rsp_predicted.push_back(apply_queue_op(mon_req));
      end
      if (req_taken || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      // watchdog
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $realtime, StallLimit);
        $display("** min_priority_queue: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.action  = ActInsert;
    req_if.key     = '0;
    rsp_if.ready   = 1'b0;
    req_total      = 0;
    rsp_count      = 0;
    err_count      = 0;
    quiet_cycles   = 0;
    src_gap        = 0;
    sink_gap       = 0;
    req_taken      = 1'b0;
    no_idle        = 1'b0;
    long_hold_done = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: empty queue first, then extremes, duplicates, unused code
    send_req(ActPeek,   key_t'(32'h1234_5678));
    send_req(ActRemove, key_t'(32'hffff_ffff));
    send_req(ActUnused, key_t'(32'h7fff_ffff));
    send_req(ActInsert, key_t'(32'h7fff_ffff));
    send_req(ActPeek,   '0);
    send_req(ActInsert, key_t'(32'h8000_0000));
    send_req(ActPeek,   '0);
    send_req(ActInsert, key_t'(-1));
    send_req(ActInsert, key_t'(0));
    send_req(ActInsert, key_t'(1));
    send_req(ActInsert, key_t'(-1));
    send_req(ActUnused, key_t'(32'h8000_0000));
    send_req(ActPeek,   key_t'(32'haaaa_5555));
    for (int i = 0; i < 7; i++) send_req(ActRemove, key_t'($urandom));
    send_req(ActPeek,   '0);
    send_req(ActRemove, '0);
    wait_idle();

    // mixed traffic with random idling; the long receiver stall lands here
    for (int i = 0; i < 230; i++) send_req(pick_action(45, 35, 15), pick_key());
    wait_idle();

    // insert-heavy burst with no idling
    no_idle  = 1'b1;
    fill_len = 80;
    for (int i = 0; i < fill_len; i++) send_req(pick_action(80, 10, 8), pick_key());
    send_req(ActPeek, '0);
    wait_idle();
    no_idle = 1'b0;

    // remove-heavy traffic that drains the queue again
    drain_len = held_keys.size() * 12 / 10 + 10;
    for (int i = 0; i < drain_len; i++) send_req(pick_action(8, 85, 5), pick_key());
    wait_idle();

    // whatever is left goes, then empty remove and peek once more
    drain_len = held_keys.size() + 2;
    for (int i = 0; i < drain_len; i++) send_req(ActRemove, pick_key());
    send_req(ActPeek, pick_key());
    wait_idle();

    repeat (4) @(posedge clk_i);
    if (rsp_predicted.size() != 0) begin
      err_count++;
      $display("%0t: %0d responses never arrived", $realtime, rsp_predicted.size());
    end
    if (err_count == 0) begin
      $display("** min_priority_queue: PASSED **");
    end else begin
      $display("** min_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule
